// ===== design/e2q_pkg.sv =====
// Shared constants for the Euler-to-quaternion block.
// Holds CORDIC arctangent table (2^-20 degree units), angle limits and widths.
package e2q_pkg;

    localparam int AngW       = 32;
    localparam int CordW      = 33;
    localparam int TabLen     = 24;
    localparam int StagesDef  = 16;

    localparam logic signed [AngW-1:0] Deg90  = 32'sd94371840;
    localparam logic signed [AngW-1:0] Deg180 = 32'sd188743680;
    localparam logic signed [CordW-1:0] GainQ30 = 33'sd652032874;

    function automatic logic signed [AngW-1:0] atan_tab(input logic [4:0] idx);
        logic signed [AngW-1:0] r;
        begin
            case (idx)
                5'd0:  r = 32'sd47185920;
                5'd1:  r = 32'sd27855475;
                5'd2:  r = 32'sd14718068;
                5'd3:  r = 32'sd7471121;
                5'd4:  r = 32'sd3750058;
                5'd5:  r = 32'sd1876857;
                5'd6:  r = 32'sd938658;
                5'd7:  r = 32'sd469358;
                5'd8:  r = 32'sd234682;
                5'd9:  r = 32'sd117342;
                5'd10: r = 32'sd58671;
                5'd11: r = 32'sd29335;
                5'd12: r = 32'sd14668;
                5'd13: r = 32'sd7334;
                5'd14: r = 32'sd3667;
                5'd15: r = 32'sd1833;
                5'd16: r = 32'sd917;
                5'd17: r = 32'sd458;
                5'd18: r = 32'sd229;
                5'd19: r = 32'sd115;
                5'd20: r = 32'sd57;
                5'd21: r = 32'sd29;
                5'd22: r = 32'sd14;
                5'd23: r = 32'sd7;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== design/euler_to_quaternion.sv =====
// Euler ZYX angles to Q1.14 quaternion: pipelined CORDIC plus product stages.
// Depends on e2q_pkg.
// Path from accepted start to result strobe: range reduction, CORDIC iterations, sign fold, products, sums, round.
// Throughput: one request per cycle; busy is tied low since nothing blocks.
// Each CORDIC iteration is one register stage; the Q30 multiplies sit in the pitch/yaw and roll product stages.
// Reset clears the valid pipeline only; the data path holds no reset.
module euler_to_quaternion #(
    parameter int CORDIC_STAGES = e2q_pkg::StagesDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] roll_deg,
    input  logic signed [15:0] pitch_deg,
    input  logic signed [15:0] yaw_deg,
    input  logic               step_raw,
    output logic               done,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic               step_flag
);

    localparam int NS = (CORDIC_STAGES < e2q_pkg::TabLen) ? CORDIC_STAGES : e2q_pkg::TabLen;
    localparam int AW = e2q_pkg::AngW;
    localparam int CW = e2q_pkg::CordW;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    logic signed [AW-1:0] zin [3];
    assign zin[0] = AW'(roll_deg)  <<< 12;
    assign zin[1] = AW'(pitch_deg) <<< 12;
    assign zin[2] = AW'(yaw_deg)   <<< 12;

    // index 0 holds the range-reduced angle, index k+1 the output of iteration k
    logic                 cv_reg  [NS+1];
    logic                 cst_reg [NS+1];
    logic [2:0]           cneg_reg[NS+1];
    logic signed [CW-1:0] cx_reg  [NS+1][3];
    logic signed [CW-1:0] cy_reg  [NS+1][3];
    logic signed [AW-1:0] cz_reg  [NS+1][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
                cv_reg[k] <= 1'b0;
        end
        else
        begin
            cv_reg[0] <= accept;
            for (int k = 0; k < NS; k++)
                cv_reg[k+1] <= cv_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 0: range reduction
        cst_reg[0] <= step_raw;
        for (int a = 0; a < 3; a++)
        begin
            cx_reg[0][a] <= e2q_pkg::GainQ30;
            cy_reg[0][a] <= '0;
            if (zin[a] > e2q_pkg::Deg90)
            begin
                cz_reg[0][a]   <= zin[a] - e2q_pkg::Deg180;
                cneg_reg[0][a] <= 1'b1;
            end
            else if (zin[a] < -e2q_pkg::Deg90)
            begin
                cz_reg[0][a]   <= zin[a] + e2q_pkg::Deg180;
                cneg_reg[0][a] <= 1'b1;
            end
            else
            begin
                cz_reg[0][a]   <= zin[a];
                cneg_reg[0][a] <= 1'b0;
            end
        end

        // CORDIC iterations
        for (int k = 0; k < NS; k++)
        begin
            cst_reg[k+1]  <= cst_reg[k];
            cneg_reg[k+1] <= cneg_reg[k];
            for (int a = 0; a < 3; a++)
            begin
                if (!cz_reg[k][a][AW-1])
                begin
                    cx_reg[k+1][a] <= cx_reg[k][a] - (cy_reg[k][a] >>> k);
                    cy_reg[k+1][a] <= cy_reg[k][a] + (cx_reg[k][a] >>> k);
                    cz_reg[k+1][a] <= cz_reg[k][a] - e2q_pkg::atan_tab(5'(k));
                end
                else
                begin
                    cx_reg[k+1][a] <= cx_reg[k][a] + (cy_reg[k][a] >>> k);
                    cy_reg[k+1][a] <= cy_reg[k][a] - (cx_reg[k][a] >>> k);
                    cz_reg[k+1][a] <= cz_reg[k][a] + e2q_pkg::atan_tab(5'(k));
                end
            end
        end
    end

    // fold sign, then pair pitch and yaw
    logic                 v1_reg, st1_reg;
    logic signed [CW-1:0] s_reg [3];
    logic signed [CW-1:0] c_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= cv_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        st1_reg <= cst_reg[NS];
        for (int a = 0; a < 3; a++)
        begin
            c_reg[a] <= cneg_reg[NS][a] ? -cx_reg[NS][a] : cx_reg[NS][a];
            s_reg[a] <= cneg_reg[NS][a] ? -cy_reg[NS][a] : cy_reg[NS][a];
        end
    end

    function automatic logic signed [CW-1:0] mq30(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        begin
            p = (2*CW)'(a) * (2*CW)'(b) + ((2*CW)'(1) <<< 29);
            return CW'(p >>> 30);
        end
    endfunction

    // stage 2: pitch/yaw products
    logic                 v2_reg, st2_reg;
    logic signed [CW-1:0] cpcy_reg, spsy_reg, cpsy_reg, spcy_reg, sr2_reg, cr2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        st2_reg  <= st1_reg;
        sr2_reg  <= s_reg[0];
        cr2_reg  <= c_reg[0];
        cpcy_reg <= mq30(c_reg[1], c_reg[2]);
        spsy_reg <= mq30(s_reg[1], s_reg[2]);
        cpsy_reg <= mq30(c_reg[1], s_reg[2]);
        spcy_reg <= mq30(s_reg[1], c_reg[2]);
    end

    // stage 3: roll products
    logic                 v3_reg, st3_reg;
    logic signed [CW-1:0] p_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        st3_reg  <= st2_reg;
        p_reg[0] <= mq30(cr2_reg, cpcy_reg);
        p_reg[1] <= mq30(sr2_reg, spsy_reg);
        p_reg[2] <= mq30(sr2_reg, cpcy_reg);
        p_reg[3] <= mq30(cr2_reg, spsy_reg);
        p_reg[4] <= mq30(cr2_reg, spcy_reg);
        p_reg[5] <= mq30(sr2_reg, cpsy_reg);
        p_reg[6] <= mq30(cr2_reg, cpsy_reg);
        p_reg[7] <= mq30(sr2_reg, spcy_reg);
    end

    // stage 4: sums
    logic                      v4_reg, st4_reg;
    logic signed [CW:0]        sum_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        st4_reg    <= st3_reg;
        sum_reg[0] <= (CW+1)'(p_reg[0]) + (CW+1)'(p_reg[1]);
        sum_reg[1] <= (CW+1)'(p_reg[2]) - (CW+1)'(p_reg[3]);
        sum_reg[2] <= (CW+1)'(p_reg[4]) + (CW+1)'(p_reg[5]);
        sum_reg[3] <= (CW+1)'(p_reg[6]) - (CW+1)'(p_reg[7]);
    end

    // stage 5: round to Q14 and saturate
    function automatic logic signed [15:0] to_q14(input logic signed [CW:0] v);
        logic signed [CW:0] r;
        begin
            r = (v + ((CW+1)'(1) <<< 15)) >>> 16;
            if (r > 16384)
                return 16'sd16384;
            else if (r < -16384)
                return -16'sd16384;
            else
                return 16'(r);
        end
    endfunction

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        quat_w    <= to_q14(sum_reg[0]);
        quat_x    <= to_q14(sum_reg[1]);
        quat_y    <= to_q14(sum_reg[2]);
        quat_z    <= to_q14(sum_reg[3]);
        step_flag <= st4_reg;
    end

    assign done = done_reg;

    a_done_lat: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |=> done)
        else $error("result strobe lost");
    a_no_spur: assert property (@(posedge clk) disable iff (!rst_n)
        !v4_reg |=> !done)
        else $error("spurious result strobe");
    a_range_w: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quat_w <= 16384 && quat_w >= -16384))
        else $error("quat_w out of range");
    a_v_chain: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |=> v3_reg)
        else $error("valid dropped in product stages");

endmodule
